>>> rtl/core/tkl_pkg.sv
// Shared types, sizes and cell operation codes for the keyed leaderboard.
package tkl_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int MAX_OUT    = 16;
  localparam int OCC_W      = $clog2(LIST_DEPTH + 1);
  localparam int READ_CNT   = (LIST_DEPTH < MAX_OUT) ? LIST_DEPTH : MAX_OUT;

  localparam int ID_W    = 32;
  localparam int SCORE_W = 32;
  localparam int POS_W   = 4;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 2;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_REMOVE,
    OP_INSERT,
    OP_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    entry_t   key;
    logic     drop;
  } cell_ctrl_t;

endpackage

>>> rtl/core/tkl_cell.sv
// One slot of the sorted list: holds an entry and trades it with its neighbors.
module tkl_cell (
  input  logic              clk_i,
  input  tkl_pkg::cell_ctrl_t ctrl_i,
  input  logic              occ_i,
  input  logic              is_tail_i,
  input  tkl_pkg::entry_t   prev_i,
  input  tkl_pkg::entry_t   next_i,
  input  tkl_pkg::entry_t   head_i,
  input  logic              match_i,
  input  logic              ge_prev_i,
  output tkl_pkg::entry_t   entry_o,
  output logic              match_o,
  output logic              ge_o
);
  import tkl_pkg::*;

  entry_t entry_q;
  logic   hit;

  assign hit     = occ_i && (entry_q.id == ctrl_i.key.id);
  assign match_o = match_i || hit;
  assign ge_o    = occ_i && (entry_q.score >= ctrl_i.key.score);
  assign entry_o = entry_q;

  // Removal closes the gap from above, insertion opens one from below, and
  // rotation walks the occupied part of the list around as a ring.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_REMOVE: begin
        if (match_o) begin
          entry_q <= next_i;
        end
      end
      OP_INSERT: begin
        if (!ctrl_i.drop && !ge_o) begin
          entry_q <= ge_prev_i ? ctrl_i.key : prev_i;
        end
      end
      OP_ROTATE: begin
        entry_q <= is_tail_i ? head_i : next_i;
      end
      default: begin
        entry_q <= entry_q;
      end
    endcase
  end

endmodule

>>> rtl/core/top_k_keyed_leaderboard_unit.sv
// Top level of the keyed leaderboard: a chain of list cells with control.
//
// The block keeps up to LIST_DEPTH entries (id, score) sorted by descending
// score. Input words arrive on the s_axis channel: tuser selects an update
// (0) or a read-out (1), tdata carries user_id and score. Results leave on
// the m_axis channel through a single output register.
// In an update, at the accepting edge every cell compares its id with the
// key and the list closes any gap left by a matching entry; then, in the
// insert state, every cell compares its score, the new entry drops into
// place and one word reports the outcome. The insert state waits while the
// output register is still full, and no new word is taken until it is done.
// A read-out rotates the occupied cells as a ring, presenting the head cell
// each cycle in which the output register is free to take it; it
// ends with the list back in its original order. Only the first MAX_OUT
// entries are sent; further rotation steps restore the order silently.
// An empty list reads out as one word with entry_valid low and tlast high.
// One input word is worked on at a time; s_axis_tready is high only while
// the block is idle. A stalled receiver simply holds the sequence in place.
// Reset empties the list; cell contents are not cleared and are never read
// before being written.
module top_k_keyed_leaderboard_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] user_id, [63:32] score
  input  logic [tkl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] mode
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] entry_id, [63:32] entry_score, [67:64] position, [71:68] zero
  output logic [tkl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [0] entry_valid, [1] stored
  output logic [tkl_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  output logic                              m_axis_tlast
);
  import tkl_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [OCC_W-1:0] rd_cnt_q, rd_cnt_d;
  entry_t           key_q;

  logic             out_valid_q;
  entry_t           out_entry_q;
  logic [POS_W-1:0] out_pos_q;
  logic             out_evalid_q, out_stored_q, out_last_q;

  logic             out_load;
  entry_t           out_entry_d;
  logic [POS_W-1:0] out_pos_d;
  logic             out_evalid_d, out_stored_d, out_last_d;

  logic       accept, out_free;
  entry_t     in_entry;
  cell_ctrl_t ctrl;

  entry_t                cell_entry [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] match_w, ge_w, ge_prev_w, occ_w, tail_w, ins_pt;

  logic [OCC_W-1:0] emit_cnt;
  logic             emitting, rd_last, rd_done;
  logic [POS_W-1:0] ins_pos;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_entry.id    = s_axis_tdata[ID_W-1:0];
  assign in_entry.score = s_axis_tdata[ID_W+SCORE_W-1:ID_W];

  // The cell row. Each cell sees its neighbors, the head for ring closure,
  // and a ripple of "an earlier cell matched" for the removal shift.
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    entry_t prev_e, next_e;
    logic   match_in;

    assign occ_w[g]  = (OCC_W'(g) < occ_q);
    assign tail_w[g] = (OCC_W'(g + 1) == occ_q);

    if (g == 0) begin : g_first
      assign prev_e       = ctrl.key;
      assign match_in     = 1'b0;
      assign ge_prev_w[g] = 1'b1;
    end else begin : g_rest
      assign prev_e       = cell_entry[g-1];
      assign match_in     = match_w[g-1];
      assign ge_prev_w[g] = ge_w[g-1];
    end

    if (g == LIST_DEPTH - 1) begin : g_last
      assign next_e = cell_entry[g];
    end else begin : g_mid
      assign next_e = cell_entry[g+1];
    end

    assign ins_pt[g] = !ge_w[g] && ge_prev_w[g];

    tkl_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (occ_w[g]),
      .is_tail_i (tail_w[g]),
      .prev_i    (prev_e),
      .next_i    (next_e),
      .head_i    (cell_entry[0]),
      .match_i   (match_in),
      .ge_prev_i (ge_prev_w[g]),
      .entry_o   (cell_entry[g]),
      .match_o   (match_w[g]),
      .ge_o      (ge_w[g])
    );
  end

  // The ge flags form a prefix, so exactly one cell marks the insertion
  // point unless every slot of a full list already ranks at or above it.
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (ins_pt[i]) begin
        ins_pos = POS_W'(i);
      end
    end
  end

  assign emit_cnt = (occ_q < OCC_W'(READ_CNT)) ? occ_q : OCC_W'(READ_CNT);
  assign emitting = (rd_cnt_q < emit_cnt);
  assign rd_last  = (rd_cnt_q == emit_cnt - OCC_W'(1));
  assign rd_done  = (rd_cnt_q == occ_q - OCC_W'(1));

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    rd_cnt_d     = rd_cnt_q;
    ctrl.op      = OP_HOLD;
    ctrl.key     = (state_q == ST_IDLE) ? in_entry : key_q;
    ctrl.drop    = ge_w[LIST_DEPTH-1];
    out_load     = 1'b0;
    out_entry_d  = key_q;
    out_pos_d    = '0;
    out_evalid_d = 1'b1;
    out_stored_d = 1'b0;
    out_last_d   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser) begin
            rd_cnt_d = '0;
            state_d  = ST_READ;
          end else begin
            ctrl.op = OP_REMOVE;
            occ_d   = occ_q - OCC_W'(match_w[LIST_DEPTH-1]);
            state_d = ST_INSERT;
          end
        end
      end
      ST_INSERT: begin
        if (out_free) begin
          ctrl.op  = OP_INSERT;
          out_load = 1'b1;
          if (!ge_w[LIST_DEPTH-1]) begin
            out_stored_d = 1'b1;
            out_pos_d    = ins_pos;
            if (occ_q < OCC_W'(LIST_DEPTH)) begin
              occ_d = occ_q + OCC_W'(1);
            end
          end
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (occ_q == '0) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_entry_d  = '0;
            out_evalid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end else if (!emitting || out_free) begin
          ctrl.op     = OP_ROTATE;
          out_load    = emitting;
          out_entry_d = cell_entry[0];
          out_pos_d   = POS_W'(rd_cnt_q);
          out_last_d  = rd_last;
          rd_cnt_d    = rd_cnt_q + OCC_W'(1);
          if (rd_done) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      rd_cnt_q <= rd_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= in_entry;
    end
    if (out_load) begin
      out_entry_q  <= out_entry_d;
      out_pos_q    <= out_pos_d;
      out_evalid_q <= out_evalid_d;
      out_stored_q <= out_stored_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - ID_W - SCORE_W - POS_W){1'b0}},
                          out_pos_q, out_entry_q.score, out_entry_q.id};
  assign m_axis_tuser  = {out_stored_q, out_evalid_q};
  assign m_axis_tlast  = out_last_q;

endmodule

>>> rtl/core/tkl_checker.sv
// Port-level checks of the keyed leaderboard, bound to the top level.
module tkl_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tkl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic [tkl_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  input logic                             m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_update_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("update not followed by an insertion cycle");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && !m_axis_tuser[1])
    else $error("empty-list word is not a lone final word");

endmodule

bind top_k_keyed_leaderboard_unit tkl_checker u_tkl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> verif/tb_top_k_keyed_leaderboard_unit.sv
// Self-checking testbench for the keyed top-K leaderboard unit.
module tb_top_k_keyed_leaderboard_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tkl_pkg::*;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  localparam int          ID_POOL      = 24;
  localparam int          SETTLE_WAIT  = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          MAX_REPORTED = 10;

  // One result word as the block should present it.
  typedef struct packed {
    logic [ID_W-1:0]    entry_id;
    logic [SCORE_W-1:0] entry_score;
    logic [POS_W-1:0]   position;
    logic               entry_valid;
    logic               stored;
    logic               last;
  } board_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;

  // Model of the list: entries in rank order and how many are held.
  entry_t      board [LIST_DEPTH];
  int          board_count;
  board_word_t due_board_words[$];

  logic [ID_W-1:0] id_pool [ID_POOL];
  int              src_idle_pct;
  int              sink_idle_pct;
  int              mismatch_count;
  int unsigned     cycle_count;

  top_k_keyed_leaderboard_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // An update drops any entry with the same id, then goes in after every
  // entry scoring at least as high. Landing past the last slot of a full
  // list means it is dropped; that covers both a score below the tail and
  // a tie with the tail.
  function automatic void board_apply_update(input logic [ID_W-1:0] id,
                                             input logic [SCORE_W-1:0] sc);
    int          n;
    int          hit;
    int          p;
    board_word_t w;
    n   = board_count;
    hit = -1;
    for (int i = 0; i < n; i++) begin
      if (hit < 0 && board[i].id == id) hit = i;
    end
    if (hit >= 0) begin
      for (int j = hit; j + 1 < n; j++) board[j] = board[j + 1];
      n--;
    end
    p = 0;
    while (p < n && board[p].score >= sc) p++;
    w.entry_id    = id;
    w.entry_score = sc;
    w.position    = '0;
    w.entry_valid = 1'b1;
    w.stored      = 1'b0;
    w.last        = 1'b1;
    if (p < LIST_DEPTH) begin
      if (n < LIST_DEPTH) n++;
      for (int i = n - 1; i > p; i--) board[i] = board[i - 1];
      board[p].id    = id;
      board[p].score = sc;
      w.position     = p[POS_W-1:0];
      w.stored       = 1'b1;
    end
    board_count = n;
    due_board_words = {due_board_words, w};
  endfunction

  function automatic void board_read_out();
    int          cnt;
    board_word_t w;
    cnt = (board_count < MAX_OUT) ? board_count : MAX_OUT;
    w   = '0;
    if (cnt == 0) begin
      w.last = 1'b1;
      due_board_words = {due_board_words, w};
    end else begin
      for (int i = 0; i < cnt; i++) begin
        w.entry_id    = board[i].id;
        w.entry_score = board[i].score;
        w.position    = i[POS_W-1:0];
        w.entry_valid = 1'b1;
        w.stored      = 1'b0;
        w.last        = (i + 1 == cnt);
        due_board_words = {due_board_words, w};
      end
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so back-to-back words drop it only in random idles.
  task automatic send_word(input logic mode, input logic [ID_W-1:0] id,
                           input logic [SCORE_W-1:0] sc);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = mode;
    s_axis_tdata  = {sc, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (mode == MODE_READ) board_read_out();
    else board_apply_update(id, sc);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every predicted word has come back.
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (due_board_words.size() != 0) @(negedge clk_i);
    repeat (SETTLE_WAIT) @(negedge clk_i);
  endtask

  task automatic test_empty_readout();
    send_word(MODE_READ, '0, '0);
  endtask

  // Extreme ids and scores, then a re-key that ties with an existing score.
  task automatic test_extreme_values();
    send_word(MODE_UPDATE, 32'h0000_0000, 32'h0000_0000);
    send_word(MODE_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(MODE_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(MODE_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Fills the list, then works the tail: a tie that falls off, inserts that
  // push the tail out, a drop below the tail, and a re-key of the tail.
  task automatic test_full_list();
    for (int i = 0; i < LIST_DEPTH - 2; i++) begin
      send_word(MODE_UPDATE, 32'h10 + i, 32'd100 * (i + 1));
    end
    send_word(MODE_UPDATE, 32'hA5A5_A5A5, 32'd0);
    send_word(MODE_UPDATE, 32'h5A5A_5A5A, 32'd50);
    send_word(MODE_UPDATE, 32'h3333_3333, 32'd60);
    send_word(MODE_UPDATE, 32'h6666_6666, 32'd50);
    send_word(MODE_UPDATE, 32'h7777_7777, 32'd49);
    send_word(MODE_UPDATE, 32'h5A5A_5A5A, 32'd10);
    send_word(MODE_UPDATE, 32'h8000_0000, 32'd2000);
    send_word(MODE_READ, '0, '0);
  endtask

  // Mostly updates on a small set of ids so the list fills and entries get
  // re-keyed; scores mix narrow ranges for ties, extremes and values near
  // the current tail so that drops and overflows happen often.
  task automatic test_random_traffic(input int count);
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] sc;
    logic [SCORE_W-1:0] tail;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 10) begin
        send_word(MODE_READ, $urandom, $urandom);
      end else begin
        id   = ($urandom_range(99) < 90) ? id_pool[$urandom_range(ID_POOL - 1)] : $urandom;
        tail = (board_count > 0) ? board[board_count - 1].score : '0;
        case ($urandom_range(3))
          0: sc = $urandom_range(15);
          1: sc = $urandom;
          2: sc = $urandom_range(1) ? '1 : '0;
          default: sc = tail + $urandom_range(2) - 1;
        endcase
        send_word(MODE_UPDATE, id, sc);
      end
    end
  endtask

  task automatic note_mismatch(input string what, input board_word_t want,
                               input board_word_t got, input logic [3:0] pad);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected id=%h score=%h pos=%0d valid=%b stored=%b last=%b",
               want.entry_id, want.entry_score, want.position, want.entry_valid,
               want.stored, want.last);
      $display("  actual   id=%h score=%h pos=%0d valid=%b stored=%b last=%b pad=%h",
               got.entry_id, got.entry_score, got.position, got.entry_valid,
               got.stored, got.last, pad);
    end
  endtask

  // Result checker: every accepted word is compared with the oldest one due.
  always @(posedge clk_i) begin
    board_word_t got;
    board_word_t want;
    logic [3:0]  pad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.entry_id    = m_axis_tdata[31:0];
      got.entry_score = m_axis_tdata[63:32];
      got.position    = m_axis_tdata[67:64];
      got.entry_valid = m_axis_tuser[0];
      got.stored      = m_axis_tuser[1];
      got.last        = m_axis_tlast;
      pad             = m_axis_tdata[71:68];
      if (due_board_words.size() == 0) begin
        note_mismatch("word with nothing due", '0, got, pad);
      end else begin
        want = due_board_words[0];
        due_board_words.delete(0);
        if (got.entry_id !== want.entry_id || got.entry_score !== want.entry_score ||
            got.position !== want.position || got.entry_valid !== want.entry_valid ||
            got.stored !== want.stored || got.last !== want.last || pad !== 4'h0) begin
          note_mismatch("word mismatch", want, got, pad);
        end
      end
    end
  end

  // The receiver stalls at random, changing only on falling edges.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top_k_keyed_leaderboard_unit NOT OK");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = MODE_UPDATE;
    src_idle_pct   = 27;
    sink_idle_pct  = 66;
    mismatch_count = 0;
    board_count    = 0;
    for (int i = 0; i < ID_POOL; i++) id_pool[i] = $urandom;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_readout();
    test_extreme_values();
    test_full_list();
    test_random_traffic(28);
    wait_drained();

    src_idle_pct  = 66;
    sink_idle_pct = 27;
    test_random_traffic(28);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(28);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("tb_top_k_keyed_leaderboard_unit OK");
    end else begin
      $display("tb_top_k_keyed_leaderboard_unit NOT OK");
    end
    $finish;
  end

endmodule
